### sv/rslt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rslt_pkg
// Shared widths and limits of the row segment line tracker.
// ----------------------------------------------------------------------------
package rslt_pkg;

  // Largest row and frame sizes that the block supports.
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 512;

  // Column index and row index widths.
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  // Register indexes of the configuration port.
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  // Threshold offset and clamp limits.
  localparam logic [8:0] LEVEL_OFFSET = 9'd30;
  localparam logic [8:0] LEVEL_MIN    = 9'd60;
  localparam logic [8:0] LEVEL_MAX    = 9'd200;

  // Division steps of the shared divider (width of the widest dividend).
  localparam int unsigned DIV_N = 28;

endpackage

### sv/row_segment_line_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_segment_line_tracker_core
// Buffers each row of a gray frame, finds the best bright run per row and
// reports a weighted target centre at the end of the frame.
// ----------------------------------------------------------------------------
// Channel | Dir | Contents
// in_     | in  | tdata: pixel[7:0]
// out_    | out | tdata: row result, tlast: frame_done
// cfg_    | in  | write enable, index (0 width, 1 height), data
//
// Pixels are taken one per cycle while a row fills the line memory.
// After the last pixel of a row the block stops taking pixels through the
// threshold division, the memory scan, the row update and the result load,
// and on the last row of a tracked frame also through the target division.
// Rows after the track has stopped skip the scan.
// The output register frees the input side: a result may wait while the
// next row already fills. Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module row_segment_line_tracker_core
  import rslt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // row_found[0], row_left[11:1], row_right[22:12], row_center[33:23],
  // row_level[41:34], track_lost[42], target_center[52:43],
  // steer_error[63:53], valid_rows_seen[73:64], zero[79:74]
  output logic [79:0] out_tdata,
  output logic        out_tlast,  // frame_done
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [10:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_FILL, S_LVL_DIV, S_SCAN, S_UPDATE, S_FINAL, S_TGT_DIV, S_EMIT
  } state_t;

  state_t state_r;

  // Configuration and effective sizes
  logic [10:0] cfg_width_r;
  logic [9:0]  cfg_height_r;
  logic [10:0] w_eff;
  logic [9:0]  h_eff;
  logic [20:0] w_recip;
  logic [7:0]  min_run;
  logic [6:0]  h_div8;
  logic [6:0]  max_lost;
  logic [6:0]  min_valid;
  logic [8:0]  sample_cnt;
  logic [COL_W-1:0] half_w;
  logic [COL_W-1:0] last_col;

  always_comb begin
    if (cfg_width_r == 11'd0) w_eff = 11'd1;
    else if (cfg_width_r > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = cfg_width_r;
    if (cfg_height_r == 10'd0) h_eff = 10'd1;
    else if (cfg_height_r > 10'(MAX_HEIGHT)) h_eff = 10'(MAX_HEIGHT);
    else h_eff = cfg_height_r;
    // Width over twelve as a multiply by a reciprocal.
    w_recip    = 21'(w_eff) * 21'd683;
    min_run    = (w_recip[20:13] < 8'd6) ? 8'd6 : w_recip[20:13];
    h_div8     = h_eff[9:3];
    max_lost   = (h_div8 < 7'd4) ? 7'd4 : h_div8;
    min_valid  = (h_div8 < 7'd6) ? 7'd6 : h_div8;
    sample_cnt = 9'((12'(w_eff) + 12'd3) >> 2);
    half_w     = COL_W'(w_eff >> 1);
    last_col   = COL_W'(w_eff - 11'd1);
  end

  // Frame and row state
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [15:0] sum_r;
  logic [COL_W-1:0] ref_r;
  logic ref_set_r;
  logic [27:0] wsum_r;
  logic [17:0] wtot_r;
  logic [9:0]  valid_r;
  logic [9:0]  lost_r;
  logic stopped_r;
  logic [7:0] level_r;
  logic [COL_W-1:0] ref_col;

  assign ref_col = ref_set_r ? ref_r : half_w;

  // Line memory
  logic [7:0] line_mem [MAX_WIDTH];
  logic [7:0] rd_data_r;
  logic [COL_W-1:0] scan_x_r;
  logic scan_issue_r;
  logic in_acc;

  assign in_tready = (state_r == S_FILL);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_mem[col_r] <= in_tdata;
    end
    rd_data_r <= line_mem[scan_x_r];
  end

  // Shared restoring divider
  logic [27:0] div_quo_r;
  logic [18:0] div_rem_r;
  logic [17:0] div_den_r;
  logic [4:0]  div_cnt_r;
  logic        div_busy_r;
  logic [18:0] div_trial;
  logic        div_fit;

  assign div_trial = {div_rem_r[17:0], div_quo_r[27]};
  assign div_fit   = (div_trial >= {1'b0, div_den_r});

  // Run detection on read data
  logic rd_vld_r;
  logic [COL_W-1:0] rd_x_r;
  logic in_run_r;
  logic [COL_W-1:0] run_start_r;
  logic bright;
  logic run_end;
  logic [COL_W-1:0] run_l;
  logic [COL_W-1:0] run_r;

  always_comb begin
    bright  = ({1'b0, rd_data_r} >= {1'b0, level_r});
    run_end = 1'b0;
    run_l   = in_run_r ? run_start_r : rd_x_r;
    run_r   = rd_x_r;
    if (in_run_r && !bright) begin
      run_end = 1'b1;
      run_r   = rd_x_r - COL_W'(1);
    end else if (bright && (rd_x_r == last_col)) begin
      run_end = 1'b1;
    end
  end

  // Scoring of a finished run
  logic end_vld_r;
  logic [COL_W-1:0] end_l_r;
  logic [COL_W-1:0] end_rr_r;
  logic [10:0] run_w;
  logic [COL_W:0] run_sum;
  logic [COL_W-1:0] run_c;
  logic signed [11:0] c_diff;
  logic [11:0] c_abs;
  logic signed [15:0] score;
  logic qualifies;
  logic signed [15:0] best_r;
  logic have_r;
  logic [COL_W-1:0] best_l_r;
  logic [COL_W-1:0] best_rr_r;

  always_comb begin
    run_w     = 11'(end_rr_r) - 11'(end_l_r) + 11'd1;
    run_sum   = {1'b0, end_l_r} + {1'b0, end_rr_r};
    run_c     = run_sum[COL_W:1];
    c_diff    = $signed(12'(run_c)) - $signed(12'(ref_col));
    c_abs     = c_diff[11] ? 12'(-c_diff) : 12'(c_diff);
    score     = $signed({3'b000, run_w, 2'b00}) - $signed({4'b0000, c_abs});
    if ((ref_col >= end_l_r) && (ref_col <= end_rr_r)) begin
      score = score + $signed({3'b000, w_eff, 2'b00});
    end
    qualifies = (run_w >= 11'(min_run));
  end

  // Row update values
  logic [COL_W-1:0] best_c;
  logic [COL_W:0]   best_sum;
  logic [9:0]  weight;
  logic [19:0] wprod;
  logic row_done;
  logic frame_bad;
  logic [8:0]  lvl_raw;
  logic [8:0]  lvl_clamp;

  always_comb begin
    best_sum  = {1'b0, best_l_r} + {1'b0, best_rr_r};
    best_c    = best_sum[COL_W:1];
    weight    = 10'(row_r) + 10'd2;
    wprod     = 20'(best_c) * 20'(weight);
    row_done  = ((10'(row_r) + 10'd1) >= h_eff);
    frame_bad = (valid_r < 10'(min_valid)) || (wtot_r == 18'd0);
    lvl_raw   = div_quo_r[8:0] + LEVEL_OFFSET;
    if (lvl_raw < LEVEL_MIN) lvl_clamp = LEVEL_MIN;
    else if (lvl_raw > LEVEL_MAX) lvl_clamp = LEVEL_MAX;
    else lvl_clamp = lvl_raw;
  end

  // Output register fields
  logic        o_found_r;
  logic [10:0] o_left_r;
  logic [10:0] o_right_r;
  logic [10:0] o_center_r;
  logic        o_lost_r;
  logic [9:0]  o_target_r;
  logic [10:0] o_err_r;
  logic        out_free;

  assign out_free = !out_tvalid || out_tready;

  // Main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      cfg_width_r  <= 11'd640;
      cfg_height_r <= 10'd480;
      col_r        <= '0;
      row_r        <= '0;
      sum_r        <= '0;
      ref_set_r    <= 1'b0;
      wsum_r       <= '0;
      wtot_r       <= '0;
      valid_r      <= '0;
      lost_r       <= '0;
      stopped_r    <= 1'b0;
      div_busy_r   <= 1'b0;
      scan_issue_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      end_vld_r    <= 1'b0;
      in_run_r     <= 1'b0;
      out_tvalid   <= 1'b0;
      scan_x_r     <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;

      unique case (state_r)
        // Store pixels and sample every fourth column.
        S_FILL: begin
          if (in_acc) begin
            if (col_r[1:0] == 2'b00) sum_r <= sum_r + 16'(in_tdata);
            if (col_r == last_col) begin
              div_quo_r  <= 28'((col_r[1:0] == 2'b00) ? sum_r + 16'(in_tdata) : sum_r);
              div_rem_r  <= '0;
              div_den_r  <= 18'(sample_cnt);
              div_cnt_r  <= 5'(DIV_N - 1);
              div_busy_r <= 1'b1;
              state_r    <= S_LVL_DIV;
            end else begin
              col_r <= col_r + COL_W'(1);
            end
          end
        end
        // Threshold from the sample mean.
        S_LVL_DIV: begin
          if (!div_busy_r) begin
            level_r  <= lvl_clamp[7:0];
            have_r   <= 1'b0;
            best_r   <= -16'sd32768;
            in_run_r <= 1'b0;
            scan_x_r <= '0;
            if (stopped_r) begin
              state_r <= S_UPDATE;
            end else begin
              scan_issue_r <= 1'b1;
              state_r      <= S_SCAN;
            end
          end
        end
        // Stream the row out of memory through run detection and scoring.
        S_SCAN: begin
          rd_vld_r <= scan_issue_r;
          rd_x_r   <= scan_x_r;
          if (scan_issue_r) begin
            if (scan_x_r == last_col) scan_issue_r <= 1'b0;
            else scan_x_r <= scan_x_r + COL_W'(1);
          end
          end_vld_r <= rd_vld_r && run_end;
          end_l_r   <= run_l;
          end_rr_r  <= run_r;
          if (rd_vld_r) begin
            if (bright && !in_run_r) run_start_r <= rd_x_r;
            in_run_r <= bright && !run_end;
          end
          if (end_vld_r && qualifies && (score > best_r)) begin
            best_r    <= score;
            best_l_r  <= end_l_r;
            best_rr_r <= end_rr_r;
            have_r    <= 1'b1;
          end
          if (!scan_issue_r && !rd_vld_r && !end_vld_r) state_r <= S_UPDATE;
        end
        // Track update for the row.
        S_UPDATE: begin
          o_found_r <= have_r;
          if (have_r) begin
            o_left_r   <= 11'(best_l_r);
            o_right_r  <= 11'(best_rr_r);
            o_center_r <= 11'(best_c);
            ref_r      <= best_c;
            ref_set_r  <= 1'b1;
            wsum_r     <= wsum_r + 28'(wprod);
            wtot_r     <= wtot_r + 18'(weight);
            valid_r    <= valid_r + 10'd1;
            lost_r     <= '0;
          end else begin
            o_left_r   <= '1;
            o_right_r  <= '1;
            o_center_r <= '1;
            if (!stopped_r && (valid_r != 10'd0)) begin
              lost_r <= lost_r + 10'd1;
              if ((lost_r + 10'd1) > 10'(max_lost)) stopped_r <= 1'b1;
            end
          end
          state_r <= S_FINAL;
        end
        // Frame result on the last row.
        S_FINAL: begin
          o_lost_r   <= 1'b0;
          o_target_r <= '0;
          o_err_r    <= '0;
          if (row_done) begin
            if (frame_bad) begin
              o_lost_r   <= 1'b1;
              o_target_r <= half_w;
              state_r    <= S_EMIT;
            end else begin
              div_quo_r  <= wsum_r;
              div_rem_r  <= '0;
              div_den_r  <= wtot_r;
              div_cnt_r  <= 5'(DIV_N - 1);
              div_busy_r <= 1'b1;
              state_r    <= S_TGT_DIV;
            end
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_TGT_DIV: begin
          if (!div_busy_r) begin
            o_target_r <= div_quo_r[COL_W-1:0];
            o_err_r    <= 11'(div_quo_r[COL_W-1:0]) - 11'(half_w);
            state_r    <= S_EMIT;
          end
        end
        // Load the output register and start the next row or frame.
        S_EMIT: begin
          if (out_free) begin
            out_tvalid <= 1'b1;
            out_tlast  <= row_done;
            out_tdata  <= {6'd0, valid_r, o_err_r, o_target_r, o_lost_r, level_r,
                           o_center_r, o_right_r, o_left_r, o_found_r};
            col_r      <= '0;
            sum_r      <= '0;
            state_r    <= S_FILL;
            if (row_done) begin
              row_r     <= '0;
              ref_set_r <= 1'b0;
              wsum_r    <= '0;
              wtot_r    <= '0;
              valid_r   <= '0;
              lost_r    <= '0;
              stopped_r <= 1'b0;
            end else begin
              row_r <= row_r + ROW_W'(1);
            end
          end
        end
        default: state_r <= S_FILL;
      endcase

      // One restoring division step per cycle.
      if (div_busy_r) begin
        div_rem_r <= div_fit ? div_trial - {1'b0, div_den_r} : div_trial;
        div_quo_r <= {div_quo_r[26:0], div_fit};
        if (div_cnt_r == 5'd0) div_busy_r <= 1'b0;
        else div_cnt_r <= div_cnt_r - 5'd1;
      end

      // A register write restarts the frame.
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_IDX_WIDTH:  cfg_width_r  <= cfg_wdata;
          CFG_IDX_HEIGHT: cfg_height_r <= cfg_wdata[9:0];
          default: ;
        endcase
        state_r   <= S_FILL;
        col_r     <= '0;
        row_r     <= '0;
        sum_r     <= '0;
        ref_set_r <= 1'b0;
        wsum_r    <= '0;
        wtot_r    <= '0;
        valid_r   <= '0;
        lost_r    <= '0;
        stopped_r <= 1'b0;
      end
    end
  end

  // Checks
  a_ready_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (state_r == S_FILL)) else $error("ready outside fill");
  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy_r |-> ((state_r == S_LVL_DIV) || (state_r == S_TGT_DIV)))
    else $error("divider busy in wrong state");
  a_run_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[0]) |-> (out_tdata[11:1] <= out_tdata[22:12]))
    else $error("chosen run has left beyond right");

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the row segment line tracker core.
// Pixel rows are streamed in under several row and frame sizes, first from a
// short table of hand-made rows and then from randomly drawn line-like rows
// with noise and dark streaks. A behavioural tracker model inside the bench
// predicts every row result, and each result transaction is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rslt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SCAN_SLACK  = 120;
  localparam int unsigned PIXEL_GOAL  = 950;

  // One row result as the block reports it.
  typedef struct {
    logic               found;
    logic signed [10:0] left_col;
    logic signed [10:0] right_col;
    logic signed [10:0] center_col;
    logic [7:0]         level;
    logic               frame_end;
    logic               lost;
    logic [9:0]         target;
    logic signed [10:0] steer;
    logic [9:0]         rows_found;
  } row_result_t;

  // One hand-made row: optional register writes, background and a bright run.
  typedef struct {
    bit  write_cfg;
    int  width_val;
    int  height_val;
    int  bg;
    int  run_lo;
    int  run_len;
    int  run_val;
    bit  typed;
    bit  exp_found;
    int  exp_level;
  } hand_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = CFG_IDX_WIDTH;
  logic [10:0] cfg_wdata = '0;

  // Tracker model state.
  int unsigned width_reg, height_reg;
  logic [7:0]  line_mem [0:2*MAX_WIDTH-1];
  int unsigned col_cnt, row_cnt, sample_acc, ref_col;
  longint unsigned centre_acc;
  int unsigned weight_acc, found_cnt, miss_cnt;
  bit          halted;

  row_result_t pending_rows[$];
  int unsigned fails = 0;
  int unsigned pixels_sent = 0;
  int unsigned rows_checked = 0;
  int unsigned frames_checked = 0;
  int unsigned lost_frames = 0;
  int unsigned cycles = 0;
  bit          long_hold_done = 1'b0;

  row_segment_line_tracker_core dut (.*);

  always #1 clk = ~clk;

  // Cycle budget guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic int unsigned used_width();
    if (width_reg < 1) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return width_reg;
  endfunction

  function automatic int unsigned used_height();
    if (height_reg < 1) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_tracking();
    col_cnt = 0;
    row_cnt = 0;
    sample_acc = 0;
    ref_col = used_width() / 2;
    centre_acc = 0;
    weight_acc = 0;
    found_cnt = 0;
    miss_cnt = 0;
    halted = 1'b0;
  endfunction

  // Best bright run of the row in bank base; the first of equal scores wins.
  function automatic bit best_run(int base, int w, int lvl, int refc,
                                  output int lo, output int hi);
    int min_len, x, start, len, l, r, c, d, score, top;
    bit have;
    min_len = (w / 12 < 6) ? 6 : w / 12;
    x = 0;
    top = -32768;
    have = 1'b0;
    while (x < w) begin
      while (x < w && line_mem[base + x] < lvl) x++;
      if (x >= w) break;
      start = x;
      while (x < w && line_mem[base + x] >= lvl) x++;
      len = x - start;
      if (len < min_len) continue;
      l = start;
      r = x - 1;
      c = (l + r) / 2;
      d = (c > refc) ? c - refc : refc - c;
      score = len * 4 - d;
      if (refc >= l && refc <= r) score += w * 4;
      if (score > top) begin
        top = score;
        lo = l;
        hi = r;
        have = 1'b1;
      end
    end
    return have;
  endfunction

  // Model one accepted pixel; queues a result at the end of each row.
  function automatic void track_pixel(logic [7:0] px);
    int unsigned w, h, base, col, lvl, max_miss, min_found, weight;
    int lo, hi;
    row_result_t res;
    w = used_width();
    h = used_height();
    base = (row_cnt & 1) * MAX_WIDTH;
    col = col_cnt % MAX_WIDTH;
    line_mem[base + col] = px;
    if ((col & 3) == 0) sample_acc += px;
    if (col + 1 < w) begin
      col_cnt = col + 1;
      return;
    end
    lvl = sample_acc / ((w + 3) / 4) + 30;
    if (lvl < 60) lvl = 60;
    if (lvl > 200) lvl = 200;
    max_miss = (h / 8 < 4) ? 4 : h / 8;
    min_found = (h / 8 < 6) ? 6 : h / 8;
    res.found = 1'b0;
    res.left_col = -11'sd1;
    res.right_col = -11'sd1;
    res.center_col = -11'sd1;
    if (!halted) begin
      if (best_run(base, w, lvl, ref_col, lo, hi)) begin
        weight = row_cnt + 2;
        res.found = 1'b1;
        res.left_col = 11'(lo);
        res.right_col = 11'(hi);
        res.center_col = 11'((lo + hi) / 2);
        ref_col = (lo + hi) / 2;
        centre_acc += longint'(ref_col) * weight;
        weight_acc += weight;
        found_cnt++;
        miss_cnt = 0;
      end else if (found_cnt > 0) begin
        miss_cnt++;
        if (miss_cnt > max_miss) halted = 1'b1;
      end
    end
    res.level = 8'(lvl);
    res.frame_end = (row_cnt + 1 >= h);
    res.lost = 1'b0;
    res.target = '0;
    res.steer = '0;
    if (res.frame_end) begin
      if (found_cnt < min_found || weight_acc == 0) begin
        res.lost = 1'b1;
        res.target = 10'(w / 2);
      end else begin
        res.target = 10'(centre_acc / weight_acc);
        res.steer = 11'(int'(centre_acc / weight_acc) - int'(w / 2));
      end
    end
    res.rows_found = 10'(found_cnt);
    pending_rows.push_back(res);
    if (res.frame_end) begin
      restart_tracking();
    end else begin
      col_cnt = 0;
      sample_acc = 0;
      row_cnt++;
    end
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch at row %0d: %s got %0d expected %0d", rows_checked, what, got, want);
    fails++;
  endtask

  // Wait for the block to drain; write_reg then writes one register.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (used_width() + SCAN_SLACK) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[10:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) width_reg = val & 11'h7FF;
    else height_reg = val & 10'h3FF;
    restart_tracking();
    @(negedge clk);
  endtask

  task automatic new_sizes(int unsigned w, int unsigned h);
    settle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
  endtask

  // Send one pixel with a random lead-in gap; called at a falling edge.
  task automatic send_pixel(logic [7:0] px);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    track_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  // One row: background drawn from bg_lo..bg_hi, run drawn from run_min..255.
  task automatic send_row(int w, int bg_lo, int bg_hi, int run_lo, int run_len,
                          int run_min);
    for (int x = 0; x < w; x++) begin
      if (x >= run_lo && x < run_lo + run_len) send_pixel(8'($urandom_range(run_min, 255)));
      else send_pixel(8'($urandom_range(bg_lo, bg_hi)));
    end
  endtask

  // Result side: random stalls, one long hold-off, field-by-field compare.
  initial begin
    int stall;
    row_result_t want;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = $urandom_range(0, 9);
      if ($urandom_range(0, 2) == 0) stall = 0;
      if (!long_hold_done && rows_checked == 12) begin
        stall = 3000;
        long_hold_done = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (pending_rows.size() == 0) begin
        $display("unexpected row result transaction");
        fails++;
      end else begin
        want = pending_rows.pop_front();
        if (out_tdata[0] !== want.found)
          report("row_found", int'(out_tdata[0]), int'(want.found));
        if (out_tdata[11:1] !== want.left_col)
          report("row_left", int'($signed(out_tdata[11:1])), int'(want.left_col));
        if (out_tdata[22:12] !== want.right_col)
          report("row_right", int'($signed(out_tdata[22:12])), int'(want.right_col));
        if (out_tdata[33:23] !== want.center_col)
          report("row_center", int'($signed(out_tdata[33:23])), int'(want.center_col));
        if (out_tdata[41:34] !== want.level)
          report("row_level", int'(out_tdata[41:34]), int'(want.level));
        if (out_tlast !== want.frame_end)
          report("frame_done", int'(out_tlast), int'(want.frame_end));
        if (out_tdata[42] !== want.lost)
          report("track_lost", int'(out_tdata[42]), int'(want.lost));
        if (out_tdata[52:43] !== want.target)
          report("target_center", int'(out_tdata[52:43]), int'(want.target));
        if (out_tdata[63:53] !== want.steer)
          report("steer_error", int'($signed(out_tdata[63:53])), int'(want.steer));
        if (out_tdata[73:64] !== want.rows_found)
          report("valid_rows_seen", int'(out_tdata[73:64]), int'(want.rows_found));
        if (out_tdata[79:74] !== 6'd0) report("padding", int'(out_tdata[79:74]), 0);
        if (want.frame_end) frames_checked++;
        if (want.frame_end && want.lost) lost_frames++;
      end
      rows_checked++;
    end
  end

  // Stimulus.
  initial begin
    hand_row_t hand [] = '{
      // Zero sizes saturate to one pixel per row, one row per frame.
      '{1, 0, 0, 0, 0, 0, 0, 1, 0, 60},
      '{0, 0, 0, 255, 0, 0, 0, 1, 0, 200},
      '{0, 0, 0, 170, 0, 0, 0, 1, 0, 200},
      // 24 columns, oversized height saturates to the largest frame.
      '{1, 24, 1023, 0, 0, 0, 0, 1, 0, 60},
      '{0, 0, 0, 255, 0, 0, 0, 1, 1, 200},
      '{0, 0, 0, 20, 8, 8, 250, 0, 0, 0},
      '{0, 0, 0, 0, 0, 6, 255, 0, 0, 0},
      '{0, 0, 0, 0, 18, 6, 255, 0, 0, 0},
      '{0, 0, 0, 10, 3, 5, 255, 0, 0, 0},
      '{0, 0, 0, 100, 0, 0, 0, 1, 0, 130},
      // Small frame: runs, then a dark streak that halts tracking.
      '{1, 12, 16, 30, 2, 8, 220, 0, 0, 0},
      '{0, 0, 0, 30, 4, 8, 220, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
      '{0, 0, 0, 30, 0, 12, 220, 0, 0, 0}
    };
    int unsigned w, h, rows, phase;
    int lo, len, kind;
    bit dark_tail;
    width_reg = 640;
    height_reg = 480;
    restart_tracking();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Hand-made rows.
    foreach (hand[i]) begin
      if (hand[i].write_cfg) new_sizes(hand[i].width_val, hand[i].height_val);
      send_row(used_width(), hand[i].bg, hand[i].bg, hand[i].run_lo, hand[i].run_len,
               hand[i].run_val);
      if (hand[i].typed) begin
        pending_rows[$].found = hand[i].exp_found;
        pending_rows[$].level = 8'(hand[i].exp_level);
      end
    end

    // Random frames of line-like rows; the first is one wide single-row frame.
    phase = 0;
    while (pixels_sent < PIXEL_GOAL || phase < 2) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 40);
      h = $urandom_range(1, 20);
      if ($urandom_range(0, 9) == 0) h = 1023;
      if (phase == 0) begin
        w = 500;
        h = 1;
      end
      new_sizes(w, h);
      w = used_width();
      rows = (phase == 0) ? 1 : $urandom_range(1, 2 * used_height() > 24 ? 24 : 2 * used_height());
      dark_tail = ($urandom_range(0, 2) == 0);
      for (int r = 0; r < rows; r++) begin
        kind = $urandom_range(0, 9);
        if (dark_tail && r > rows / 3) kind = 7;
        lo = $urandom_range(0, w - 1);
        len = $urandom_range(1, w - lo);
        if (kind < 6) send_row(w, 0, 90, lo, len, $urandom_range(120, 255));
        else if (kind < 8) send_row(w, 0, 60, 0, 0, 0);
        else send_row(w, 0, 255, 0, 0, 0);
      end
      phase++;
    end

    // Drain.
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (used_width() + SCAN_SLACK) @(posedge clk);
    $display("covered %0d pixels in %0d size settings: %0d rows and %0d frames checked",
             pixels_sent, phase + 3, rows_checked, frames_checked);
    $display("%0d frames reported a lost track; %0d mismatches", lost_frames, fails);
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
